### rtl/core/pfcp_pkg.sv
// ----------------------------------------------------------------------------
// pfcp_pkg
// Types and constants shared by the PFCP transaction engine.
// ----------------------------------------------------------------------------
package pfcp_pkg;

  localparam logic [2:0] CMD_CREATE   = 3'd0;
  localparam logic [2:0] CMD_TRANSMIT = 3'd1;
  localparam logic [2:0] CMD_RECEIVE  = 3'd2;
  localparam logic [2:0] CMD_COMMIT   = 3'd3;
  localparam logic [2:0] CMD_RSP_TO   = 3'd4;
  localparam logic [2:0] CMD_HOLD_TO  = 3'd5;
  localparam logic [2:0] CMD_DELETE   = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ERR  = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [1:0] RT_NONE  = 2'd0;
  localparam logic [1:0] RT_START = 2'd1;
  localparam logic [1:0] RT_STOP  = 2'd2;

  localparam logic [1:0] STG_NONE  = 2'd0;
  localparam logic [1:0] STG_INIT  = 2'd1;
  localparam logic [1:0] STG_FINAL = 2'd2;

  localparam logic [1:0] REG_RSP_RETRIES  = 2'd0;
  localparam logic [1:0] REG_HOLD_RETRIES = 2'd1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  slot;
    logic [3:0]  peer;
    logic [7:0]  msg_type;
    logic [23:0] seq_num;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  result_slot;
    logic [23:0] result_xid;
    logic [1:0]  send_step;
    logic [1:0]  response_timer;
    logic        holding_timer_start;
    logic        released;
    logic        gave_up;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EXEC, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic scan_clr;  // reset scan pointer
    logic scan_step; // examine one slot, advance
    logic fetch;     // read stored message type for execution
    logic exec;      // apply command, build result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
  } dp_sts_t;

  function automatic logic [1:0] stage_of(input logic [7:0] t);
    case (t)
      8'd1, 8'd5, 8'd7, 8'd9, 8'd50, 8'd52, 8'd54, 8'd56: stage_of = STG_INIT;
      8'd2, 8'd6, 8'd8, 8'd10, 8'd11, 8'd51, 8'd53, 8'd55, 8'd57: stage_of = STG_FINAL;
      default: stage_of = STG_NONE;
    endcase
  endfunction

endpackage

### rtl/core/pfcp_transaction_engine.sv
// ----------------------------------------------------------------------------
// pfcp_transaction_engine
// PFCP request/response transaction table with timer and resend control.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command beat (cmd, slot, peer, msg_type, seq_num) per item.
//   out_* : one result beat per command, held until out_stall is low.
//   cfg_* : APB-style write/read of response_retries (0x0) and
//           holding_retries (0x4); pready is always high.
// Timing: each beat walks the whole table, one slot per cycle, to find a
//   matching transaction and the first free slot. The next beat is taken
//   the cycle after the result is taken, so a new beat is not accepted
//   while the last one is still being scanned, executed or presented.
// Reset (rst_n low, synchronous): all slots free, id counter zero,
//   retries back to 3 and 4.
// A stalled result holds its value; input stays stalled meanwhile.
// ----------------------------------------------------------------------------
module pfcp_transaction_engine #(
  parameter int NUM_SLOTS    = 16,
  parameter int NUM_PEERS    = 16,
  parameter int MAX_LOCAL_ID = 8388608
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pfcp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pfcp_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import pfcp_pkg::*;

  logic [3:0] rsp_r, hold_r;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [1:0] ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[1:0] == 2'd0 ? {1'b0, cfg_paddr[2]} : 2'd3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_r  <= 4'd3;
      hold_r <= 4'd4;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        REG_RSP_RETRIES:  rsp_r  <= cfg_pwdata[3:0];
        REG_HOLD_RETRIES: hold_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_RSP_RETRIES:  cfg_prdata = {28'd0, rsp_r};
      REG_HOLD_RETRIES: cfg_prdata = {28'd0, hold_r};
      default:          cfg_prdata = '0;
    endcase
  end

  pfcp_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  pfcp_dp #(.NUM_SLOTS(NUM_SLOTS), .NUM_PEERS(NUM_PEERS),
            .MAX_LOCAL_ID(MAX_LOCAL_ID)) u_dp (
    .clk, .rst_n, .in_data, .cmd, .sts,
    .rsp_retries(rsp_r), .hold_retries(hold_r), .out_data
  );
endmodule

### rtl/core/pfcp_ctrl.sv
// ----------------------------------------------------------------------------
// pfcp_ctrl
// Sequencer: accept beat, scan the table, execute, present the result.
// ----------------------------------------------------------------------------
module pfcp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pfcp_pkg::dp_sts_t sts,
  output pfcp_pkg::dp_cmd_t cmd
);
  import pfcp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_SCAN;
      S_SCAN: if (sts.scan_done) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall     = 1'b0;
        cmd.load     = in_valid;
        cmd.scan_clr = 1'b1;
      end
      S_SCAN: begin
        cmd.scan_step = !sts.scan_done;
        cmd.fetch     = sts.scan_done;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("out_valid outside S_OUT");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_exec_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid) else $error("exec not followed by result");
`endif
endmodule

### rtl/core/pfcp_dp.sv
// ----------------------------------------------------------------------------
// pfcp_dp
// Transaction table, one-slot-a-cycle match/free scan and command execution.
// ----------------------------------------------------------------------------
module pfcp_dp #(
  parameter int NUM_SLOTS    = 16,
  parameter int NUM_PEERS    = 16,
  parameter int MAX_LOCAL_ID = 8388608
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pfcp_pkg::in_item_t in_data,
  input  pfcp_pkg::dp_cmd_t  cmd,
  output pfcp_pkg::dp_sts_t  sts,
  input  logic [3:0]         rsp_retries,
  input  logic [3:0]         hold_retries,
  output pfcp_pkg::out_item_t out_data
);
  import pfcp_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  logic [NUM_SLOTS-1:0] valid_r;
  logic                 local_r [NUM_SLOTS];
  logic [3:0]           peer_r  [NUM_SLOTS];
  logic [23:0]          id_r    [NUM_SLOTS];
  logic [1:0]           step_r  [NUM_SLOTS];
  logic [7:0]           types_r [NUM_SLOTS][3];
  logic [2:0]           stored_r[NUM_SLOTS];
  logic [3:0]           sends_r [NUM_SLOTS];
  logic [3:0]           holds_r [NUM_SLOTS];
  logic [23:0]          next_id_r;

  in_item_t  it_r;
  out_item_t res_r;
  logic [CW-1:0] ptr_r;
  logic          hit_r, free_f_r;
  logic [SW-1:0] hit_s_r, free_s_r;
  logic [7:0]    types_q_r;

  logic [SW-1:0] pidx;
  assign pidx = ptr_r[SW-1:0];
  assign sts.scan_done = (ptr_r == CW'(NUM_SLOTS));
  assign out_data = res_r;

  logic want_local;
  assign want_local = (stage_of(it_r.msg_type) == STG_FINAL);

  always_ff @(posedge clk) begin
    if (cmd.load) it_r <= in_data;
    if (cmd.scan_clr) begin
      ptr_r <= '0; hit_r <= 1'b0; free_f_r <= 1'b0;
    end else if (cmd.scan_step) begin
      ptr_r <= ptr_r + CW'(1);
      if (!hit_r && valid_r[pidx] && local_r[pidx] == want_local &&
          peer_r[pidx] == it_r.peer && id_r[pidx] == it_r.seq_num) begin
        hit_r <= 1'b1; hit_s_r <= pidx;
      end
      if (!free_f_r && !valid_r[pidx]) begin
        free_f_r <= 1'b1; free_s_r <= pidx;
      end
    end
  end

  // execution
  logic [SW-1:0] s;
  logic          slot_ok;
  logic [1:0]    st, stg, cstg;
  logic [23:0]   xid;
  logic [7:0]    last_t;
  logic [SW-1:0] fs;
  logic [1:0]    fk;

  always_comb begin
    s = it_r.slot[SW-1:0];
    slot_ok = (32'(it_r.slot) < NUM_SLOTS) && valid_r[s];
    st = step_r[s];
    xid = id_r[s];
    stg = stage_of(it_r.msg_type);
    last_t = types_q_r;
    cstg = stage_of(last_t);
  end

  // receive needs the first type of the matched slot, commit the last one
  always_comb begin
    if (it_r.cmd == CMD_RECEIVE) begin
      fs = hit_s_r; fk = 2'd0;
    end else begin
      fs = s; fk = (st != 2'd0) ? st - 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) types_q_r <= types_r[fs][fk];
  end

  function automatic logic [1:0] snd(input logic [2:0] m, input logic [1:0] k);
    snd = (k <= 2'd2 && m[k]) ? k + 2'd1 : 2'd0;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      next_id_r <= '0;
    end else if (cmd.exec) begin
      out_item_t r;
      logic [SW-1:0] rs;
      logic [23:0] nid;
      logic [1:0] rst_st;
      logic err, dup, hold_f, is_local;
      logic [2:0] mst;
      r = '0;
      rs = '0; nid = '0; rst_st = '0; err = 1'b0; dup = 1'b0;
      hold_f = 1'b0; is_local = 1'b0; mst = '0;
      case (it_r.cmd)
        CMD_CREATE: begin
          if (32'(it_r.peer) >= NUM_PEERS) r.status = ST_ERR;
          else if (!free_f_r) r.status = ST_FULL;
          else begin
            nid = (32'(next_id_r) >= MAX_LOCAL_ID) ? 24'd1 : next_id_r + 24'd1;
            next_id_r <= nid;
            valid_r[free_s_r] <= 1'b1; local_r[free_s_r] <= 1'b1;
            peer_r[free_s_r] <= it_r.peer; id_r[free_s_r] <= nid;
            step_r[free_s_r] <= '0; stored_r[free_s_r] <= '0;
            sends_r[free_s_r] <= rsp_retries; holds_r[free_s_r] <= hold_retries;
            r.result_slot = 4'(free_s_r); r.result_xid = nid;
          end
        end
        CMD_RECEIVE: begin
          if (32'(it_r.peer) >= NUM_PEERS || stg == STG_NONE) r.status = ST_ERR;
          else if (!hit_r && !free_f_r) r.status = ST_FULL;
          else begin
            if (hit_r) begin
              rs = hit_s_r; rst_st = step_r[rs]; is_local = local_r[rs];
              nid = id_r[rs]; mst = stored_r[rs];
            end else begin
              rs = free_s_r; rst_st = '0; is_local = 1'b0; nid = it_r.seq_num;
              valid_r[rs] <= 1'b1; local_r[rs] <= 1'b0; peer_r[rs] <= it_r.peer;
              id_r[rs] <= it_r.seq_num; stored_r[rs] <= '0;
              sends_r[rs] <= rsp_retries; holds_r[rs] <= hold_retries;
            end
            r.result_slot = 4'(rs); r.result_xid = nid;
            if (is_local) err = !(stg == STG_FINAL && rst_st == 2'd1);
            else if (stg == STG_INIT) begin
              if (rst_st >= 2'd1 && types_q_r == it_r.msg_type) begin
                if (rst_st == 2'd3) err = 1'b1;
                else dup = 1'b1;
              end else if (rst_st != 2'd0) err = 1'b1;
              else hold_f = 1'b1;
            end else err = (rst_st != 2'd2);
            if (err) begin
              valid_r[rs] <= 1'b0;
              r.status = ST_ERR; r.released = 1'b1;
              if (!hit_r) step_r[rs] <= '0;
            end else if (dup) begin
              r.status = ST_DUP; r.send_step = snd(mst, 2'd1);
              r.holding_timer_start = (snd(mst, 2'd1) != 2'd0);
            end else begin
              types_r[rs][rst_st] <= it_r.msg_type;
              step_r[rs] <= rst_st + 2'd1;
              r.response_timer = RT_STOP; r.holding_timer_start = hold_f;
            end
          end
        end
        default: begin
          r.result_slot = it_r.slot;
          if (it_r.cmd == 3'd7 || !slot_ok) r.status = ST_ERR;
          else begin
            r.result_xid = xid;
            case (it_r.cmd)
              CMD_TRANSMIT: begin
                if (local_r[s]) err = !((stg == STG_INIT && st == 2'd0) ||
                                        (stg == STG_FINAL && st == 2'd2));
                else err = !(stg == STG_FINAL && st == 2'd1);
                if (err) r.status = ST_ERR;
                else begin
                  types_r[s][st] <= it_r.msg_type;
                  stored_r[s] <= stored_r[s] | (3'd1 << st);
                  step_r[s] <= st + 2'd1;
                end
              end
              CMD_COMMIT: begin
                // dup flags "send", err stays set for error release
                err = 1'b1;
                if (st != 2'd0) begin
                  if (local_r[s]) begin
                    if (cstg == STG_INIT && st == 2'd1) begin
                      dup = 1'b1; r.response_timer = RT_START;
                    end else if (cstg == STG_FINAL && st == 2'd2) err = 1'b0;
                    else if (cstg == STG_FINAL && st == 2'd3) dup = 1'b1;
                  end else begin
                    if (cstg == STG_FINAL && st == 2'd3) err = 1'b0;
                    else if (cstg == STG_FINAL && st == 2'd2) dup = 1'b1;
                  end
                end
                if (dup) r.send_step = snd(stored_r[s], st - 2'd1);
                else begin
                  valid_r[s] <= 1'b0; r.released = 1'b1;
                  r.status = err ? ST_ERR : ST_OK;
                end
              end
              CMD_RSP_TO: begin
                if (sends_r[s] > 4'd1) begin
                  sends_r[s] <= sends_r[s] - 4'd1;
                  r.send_step = (st != 2'd0) ? snd(stored_r[s], st - 2'd1) : 2'd0;
                  r.response_timer = RT_START;
                end else begin
                  sends_r[s] <= '0; valid_r[s] <= 1'b0;
                  r.released = 1'b1; r.gave_up = 1'b1;
                end
              end
              CMD_HOLD_TO: begin
                if (holds_r[s] > 4'd1) begin
                  holds_r[s] <= holds_r[s] - 4'd1; r.holding_timer_start = 1'b1;
                end else begin
                  holds_r[s] <= '0; valid_r[s] <= 1'b0; r.released = 1'b1;
                end
              end
              default: begin
                valid_r[s] <= 1'b0; r.released = 1'b1;
              end
            endcase
          end
        end
      endcase
      res_r <= r;
    end
  end
endmodule
